@@ src/tsched_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsched_pkg
// Shared types, codes and defaults of the tick-driven task scheduler.
// ----------------------------------------------------------------------------
package tsched_pkg;

   localparam int NUM_TASKS_DEF = 8;
   localparam int TICK_BITS_DEF = 16;

   // Fixed field widths of the transaction ports.
   localparam int ID_W    = 3;
   localparam int SVC_W   = 8;
   localparam int OUT16_W = 16;
   localparam int QUANT_W = 4;

   // Configuration port.
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;
   localparam int REG_IDX_W = 1;
   localparam logic [REG_IDX_W-1:0] REG_MODE    = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_QUANTUM = 1'b1;

   localparam logic                 MODE_RESET    = 1'b1;
   localparam logic [QUANT_W-1:0]   QUANTUM_RESET = 4'd3;

   // Item kinds and scheduling modes.
   localparam logic KIND_ARRIVAL = 1'b0;
   localparam logic KIND_TICK    = 1'b1;
   localparam logic MODE_FCFS    = 1'b0;
   localparam logic MODE_RR      = 1'b1;

   localparam logic [OUT16_W-1:0] WAIT_MAX = 16'hFFFF;

   typedef struct packed {
      logic                mode;
      logic [QUANT_W-1:0]  quantum;
   } cfg_type;

   typedef struct packed {
      logic latch;    // capture the accepted transaction
      logic arrive;   // enqueue or reject an arrival
      logic charge;   // charge one tick to the running task
      logic select;   // rotate or dispatch
      logic age;      // age queued tasks, advance tick and slice phase
      logic report;   // load the result register
   } cmd_type;

   typedef struct packed {
      logic in_is_tick;
   } sts_type;

endpackage : tsched_pkg
`default_nettype wire

@@ src/tsched_csr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsched_csr
// Configuration registers: scheduling mode and round robin quantum.
// ----------------------------------------------------------------------------
module tsched_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [tsched_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [tsched_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [tsched_pkg::CSR_DW-1:0] csr_prdata,
   output logic                               csr_pready,
   output tsched_pkg::cfg_type                cfg
);

   logic                              mode_ff, mode_in;
   logic [tsched_pkg::QUANT_W-1:0]    quantum_ff, quantum_in;
   logic [tsched_pkg::REG_IDX_W-1:0]  reg_idx;
   logic                              wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[2 +: tsched_pkg::REG_IDX_W];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      mode_in    = mode_ff;
      quantum_in = quantum_ff;
      if (wr_en) begin
         case (reg_idx)
            tsched_pkg::REG_MODE: begin
               mode_in = csr_pwdata[0];
            end
            tsched_pkg::REG_QUANTUM: begin
               quantum_in = csr_pwdata[tsched_pkg::QUANT_W-1:0];
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         tsched_pkg::REG_MODE: begin
            csr_prdata = tsched_pkg::CSR_DW'(mode_ff);
         end
         tsched_pkg::REG_QUANTUM: begin
            csr_prdata = tsched_pkg::CSR_DW'(quantum_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= tsched_pkg::MODE_RESET;
         quantum_ff <= tsched_pkg::QUANTUM_RESET;
      end else begin
         mode_ff    <= mode_in;
         quantum_ff <= quantum_in;
      end
   end

   assign cfg.mode    = mode_ff;
   assign cfg.quantum = quantum_ff;

endmodule : tsched_csr
`default_nettype wire

@@ src/tsched_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsched_ctrl
// Sequencer of the scheduler: steps one transaction through its phases and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module tsched_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  tsched_pkg::sts_type sts,
   output tsched_pkg::cmd_type cmd
);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
   localparam logic [ST_W-1:0] ST_ARRIVE = 3'd1;
   localparam logic [ST_W-1:0] ST_CHARGE = 3'd2;
   localparam logic [ST_W-1:0] ST_SELECT = 3'd3;
   localparam logic [ST_W-1:0] ST_AGE    = 3'd4;
   localparam logic [ST_W-1:0] ST_REPORT = 3'd5;

   logic [ST_W-1:0] state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;
   logic            accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   // The result register can be loaded when empty or emptied in this cycle.
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.latch = 1'b1;
               state_in  = (sts.in_is_tick == tsched_pkg::KIND_TICK) ? ST_CHARGE : ST_ARRIVE;
            end
         end
         ST_ARRIVE: begin
            cmd.arrive = 1'b1;
            state_in   = ST_REPORT;
         end
         ST_CHARGE: begin
            cmd.charge = 1'b1;
            state_in   = ST_SELECT;
         end
         ST_SELECT: begin
            cmd.select = 1'b1;
            state_in   = ST_AGE;
         end
         ST_AGE: begin
            cmd.age  = 1'b1;
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (out_free) begin
               cmd.report = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.report) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A new result only ever appears after the report step.
   a_rsp_from_report: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_REPORT))
      else $error("result valid rose outside the report step");

   // An accepted transaction always starts one of the two work sequences.
   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_ARRIVE || state_ff == ST_CHARGE))
      else $error("accepted transaction did not start processing");

endmodule : tsched_ctrl
`default_nettype wire

@@ src/tsched_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsched_dp
// Scheduler datapath: ready queue, per-task records, processor state, tick
// and slice counters, and the result register.
// ----------------------------------------------------------------------------
module tsched_dp #(
   parameter int NUM_TASKS = tsched_pkg::NUM_TASKS_DEF,
   parameter int TICK_BITS = tsched_pkg::TICK_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  tsched_pkg::cmd_type                    cmd,
   output tsched_pkg::sts_type                    sts,
   input  tsched_pkg::cfg_type                    cfg,
   input  wire logic                              req_kind,
   input  wire logic [tsched_pkg::ID_W-1:0]       req_task_id,
   input  wire logic [tsched_pkg::SVC_W-1:0]      req_service_time,
   output logic      [tsched_pkg::OUT16_W-1:0]    rsp_tick_number,
   output logic                                   rsp_running_valid,
   output logic      [tsched_pkg::ID_W-1:0]       rsp_running_id,
   output logic      [tsched_pkg::SVC_W-1:0]      rsp_remaining,
   output logic                                   rsp_done_valid,
   output logic      [tsched_pkg::ID_W-1:0]       rsp_done_id,
   output logic      [tsched_pkg::OUT16_W-1:0]    rsp_done_wait,
   output logic      [tsched_pkg::OUT16_W-1:0]    rsp_done_turnaround,
   output logic                                   rsp_rejected
);

   localparam int IDW = $clog2(NUM_TASKS);
   localparam int CW  = $clog2(NUM_TASKS + 1);
   localparam int SW  = CW + 1;
   localparam int SVW = tsched_pkg::SVC_W;
   localparam int OW  = tsched_pkg::OUT16_W;
   localparam int QW  = tsched_pkg::QUANT_W;

   // Ready queue and per-task records.
   logic [IDW-1:0]       fifo_ff      [NUM_TASKS];
   logic [IDW-1:0]       fifo_in      [NUM_TASKS];
   logic [SVW-1:0]       remain_ff    [NUM_TASKS];
   logic [SVW-1:0]       remain_in    [NUM_TASKS];
   logic [OW-1:0]        wait_ff      [NUM_TASKS];
   logic [OW-1:0]        wait_in      [NUM_TASKS];
   logic [TICK_BITS-1:0] arrival_ff   [NUM_TASKS];
   logic [TICK_BITS-1:0] arrival_in   [NUM_TASKS];
   logic [NUM_TASKS-1:0] active_ff, active_in;

   logic [IDW-1:0]       head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic [IDW-1:0]       cpu_ff, cpu_in;
   logic [TICK_BITS-1:0] tick_ff, tick_in;
   logic [QW-1:0]        phase_ff, phase_in;

   // Captured transaction and per-item flags.
   logic [tsched_pkg::ID_W-1:0] id_ff, id_in;
   logic [SVW-1:0]              svc_ff, svc_in;
   logic [TICK_BITS-1:0]        now_ff, now_in;
   logic                        dvalid_ff, dvalid_in;
   logic [IDW-1:0]              did_ff, did_in;
   logic [OW-1:0]               dwait_ff, dwait_in;
   logic [OW-1:0]               dturn_ff, dturn_in;
   logic                        rej_ff, rej_in;

   // Result register.
   logic [OW-1:0]               o_tick_ff, o_tick_in;
   logic                        o_rv_ff, o_rv_in;
   logic [tsched_pkg::ID_W-1:0] o_rid_ff, o_rid_in;
   logic [SVW-1:0]              o_rem_ff, o_rem_in;
   logic                        o_dv_ff, o_dv_in;
   logic [tsched_pkg::ID_W-1:0] o_did_ff, o_did_in;
   logic [OW-1:0]               o_dwait_ff, o_dwait_in;
   logic [OW-1:0]               o_dturn_ff, o_dturn_in;
   logic                        o_rej_ff, o_rej_in;

   logic [IDW-1:0]  id_idx;
   logic            id_out_of_range;
   logic [SW-1:0]   tail_sum;
   logic [IDW-1:0]  tail_idx;
   logic [IDW-1:0]  head_next;
   logic [QW-1:0]   q_eff;
   logic [QW:0]     phase_inc;
   logic [TICK_BITS-1:0] turn_full;

   assign sts.in_is_tick = req_kind;

   assign id_idx          = IDW'(id_ff);
   assign id_out_of_range = (32'(id_ff) >= 32'(NUM_TASKS));
   assign tail_sum        = SW'(head_ff) + SW'(count_ff);
   assign tail_idx        = (tail_sum >= SW'(NUM_TASKS)) ? IDW'(tail_sum - SW'(NUM_TASKS))
                                                         : IDW'(tail_sum);
   assign head_next       = (head_ff == IDW'(NUM_TASKS - 1)) ? '0 : head_ff + 1'b1;
   assign q_eff           = (cfg.quantum == '0) ? QW'(1) : cfg.quantum;
   assign phase_inc       = {1'b0, phase_ff} + 1'b1;
   assign turn_full       = now_ff - arrival_ff[cpu_ff];

   always_comb begin
      fifo_in    = fifo_ff;
      remain_in  = remain_ff;
      wait_in    = wait_ff;
      arrival_in = arrival_ff;
      active_in  = active_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      cpu_in     = cpu_ff;
      tick_in    = tick_ff;
      phase_in   = phase_ff;
      id_in      = id_ff;
      svc_in     = svc_ff;
      now_in     = now_ff;
      dvalid_in  = dvalid_ff;
      did_in     = did_ff;
      dwait_in   = dwait_ff;
      dturn_in   = dturn_ff;
      rej_in     = rej_ff;

      if (cmd.latch) begin
         id_in     = req_task_id;
         svc_in    = req_service_time;
         now_in    = tick_ff;
         dvalid_in = 1'b0;
         did_in    = '0;
         dwait_in  = '0;
         dturn_in  = '0;
         rej_in    = 1'b0;
      end

      if (cmd.arrive) begin
         if (id_out_of_range || active_ff[id_idx] || (count_ff >= CW'(NUM_TASKS))) begin
            rej_in = 1'b1;
         end else begin
            remain_in[id_idx]  = (svc_ff == '0) ? SVW'(1) : svc_ff;
            wait_in[id_idx]    = '0;
            arrival_in[id_idx] = now_ff;
            active_in[id_idx]  = 1'b1;
            fifo_in[tail_idx]  = id_idx;
            count_in           = count_ff + 1'b1;
         end
      end

      if (cmd.charge && busy_ff) begin
         if (remain_ff[cpu_ff] <= SVW'(1)) begin
            remain_in[cpu_ff] = '0;
            active_in[cpu_ff] = 1'b0;
            busy_in           = 1'b0;
            dvalid_in         = 1'b1;
            did_in            = cpu_ff;
            dwait_in          = wait_ff[cpu_ff];
            dturn_in          = OW'(turn_full);
         end else begin
            remain_in[cpu_ff] = remain_ff[cpu_ff] - 1'b1;
         end
      end

      if (cmd.select && (count_ff != '0)) begin
         if ((cfg.mode == tsched_pkg::MODE_RR) && busy_ff && (phase_ff == '0)) begin
            // Running task goes to the rear while the head takes over; the
            // tail slot never equals the head slot here since a task runs.
            fifo_in[tail_idx] = cpu_ff;
            cpu_in            = fifo_ff[head_ff];
            head_in           = head_next;
         end else if (!busy_ff) begin
            cpu_in   = fifo_ff[head_ff];
            busy_in  = 1'b1;
            head_in  = head_next;
            count_in = count_ff - 1'b1;
         end
      end

      if (cmd.age) begin
         // Every active task other than the running one sits in the queue.
         for (int t = 0; t < NUM_TASKS; t++) begin
            if (active_ff[t] && !(busy_ff && (cpu_ff == IDW'(t))) &&
                (wait_ff[t] != tsched_pkg::WAIT_MAX)) begin
               wait_in[t] = wait_ff[t] + 1'b1;
            end
         end
         phase_in = (phase_inc >= {1'b0, q_eff}) ? '0 : phase_inc[QW-1:0];
         tick_in  = tick_ff + 1'b1;
      end
   end

   always_comb begin
      o_tick_in  = o_tick_ff;
      o_rv_in    = o_rv_ff;
      o_rid_in   = o_rid_ff;
      o_rem_in   = o_rem_ff;
      o_dv_in    = o_dv_ff;
      o_did_in   = o_did_ff;
      o_dwait_in = o_dwait_ff;
      o_dturn_in = o_dturn_ff;
      o_rej_in   = o_rej_ff;
      if (cmd.report) begin
         o_tick_in  = OW'(now_ff);
         o_rv_in    = busy_ff;
         o_rid_in   = busy_ff ? tsched_pkg::ID_W'(cpu_ff) : '0;
         o_rem_in   = busy_ff ? remain_ff[cpu_ff] : '0;
         o_dv_in    = dvalid_ff;
         o_did_in   = tsched_pkg::ID_W'(did_ff);
         o_dwait_in = dwait_ff;
         o_dturn_in = dturn_ff;
         o_rej_in   = rej_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         head_ff   <= '0;
         count_ff  <= '0;
         busy_ff   <= 1'b0;
         cpu_ff    <= '0;
         tick_ff   <= '0;
         phase_ff  <= '0;
      end else begin
         active_ff <= active_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         busy_ff   <= busy_in;
         cpu_ff    <= cpu_in;
         tick_ff   <= tick_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      fifo_ff    <= fifo_in;
      remain_ff  <= remain_in;
      wait_ff    <= wait_in;
      arrival_ff <= arrival_in;
      id_ff      <= id_in;
      svc_ff     <= svc_in;
      now_ff     <= now_in;
      dvalid_ff  <= dvalid_in;
      did_ff     <= did_in;
      dwait_ff   <= dwait_in;
      dturn_ff   <= dturn_in;
      rej_ff     <= rej_in;
      o_tick_ff  <= o_tick_in;
      o_rv_ff    <= o_rv_in;
      o_rid_ff   <= o_rid_in;
      o_rem_ff   <= o_rem_in;
      o_dv_ff    <= o_dv_in;
      o_did_ff   <= o_did_in;
      o_dwait_ff <= o_dwait_in;
      o_dturn_ff <= o_dturn_in;
      o_rej_ff   <= o_rej_in;
   end

   assign rsp_tick_number     = o_tick_ff;
   assign rsp_running_valid   = o_rv_ff;
   assign rsp_running_id      = o_rid_ff;
   assign rsp_remaining       = o_rem_ff;
   assign rsp_done_valid      = o_dv_ff;
   assign rsp_done_id         = o_did_ff;
   assign rsp_done_wait       = o_dwait_ff;
   assign rsp_done_turnaround = o_dturn_ff;
   assign rsp_rejected        = o_rej_ff;

   // Every active task is either queued or on the processor, never both.
   a_active_accounting: assert property (@(posedge clock) disable iff (reset)
      $countones(active_ff) == (32'(count_ff) + 32'(busy_ff)))
      else $error("active task count disagrees with queue and processor");

   // The task on the processor is always an active one.
   a_running_active: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> active_ff[cpu_ff])
      else $error("running task is not marked active");

   // A completion is only recorded by the charge step of a busy processor.
   a_done_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(dvalid_ff) |-> $past(cmd.charge && busy_ff))
      else $error("completion recorded without a running task");

endmodule : tsched_dp
`default_nettype wire

@@ src/task_scheduler_fcfs_round_robin_top.sv @@
`default_nettype none
// An arrival transaction passes through the arrive and report steps, a tick
// transaction through the charge, select, age and report steps; the report
// step loads the result register once it is free. A new transaction is taken
// only after the previous one has left the report step, so one is in flight.
// Reset (synchronous) empties the queue, idles the processor, zeroes the
// counters, and sets round robin mode with a quantum of 3.
// ----------------------------------------------------------------------------
// task_scheduler_fcfs_round_robin_top
// Tick-driven task scheduler with first come first served and round robin
// modes, one result transaction per input transaction.
// ----------------------------------------------------------------------------
module task_scheduler_fcfs_round_robin_top #(
   parameter int NUM_TASKS = tsched_pkg::NUM_TASKS_DEF,
   parameter int TICK_BITS = tsched_pkg::TICK_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_kind,
   input  wire logic [tsched_pkg::ID_W-1:0]       req_task_id,
   input  wire logic [tsched_pkg::SVC_W-1:0]      req_service_time,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [tsched_pkg::OUT16_W-1:0]    rsp_tick_number,
   output logic                                   rsp_running_valid,
   output logic      [tsched_pkg::ID_W-1:0]       rsp_running_id,
   output logic      [tsched_pkg::SVC_W-1:0]      rsp_remaining,
   output logic                                   rsp_done_valid,
   output logic      [tsched_pkg::ID_W-1:0]       rsp_done_id,
   output logic      [tsched_pkg::OUT16_W-1:0]    rsp_done_wait,
   output logic      [tsched_pkg::OUT16_W-1:0]    rsp_done_turnaround,
   output logic                                   rsp_rejected,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [tsched_pkg::CSR_AW-1:0]     csr_paddr,
   input  wire logic [tsched_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic      [tsched_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                                   csr_pready
);

   tsched_pkg::cfg_type cfg;
   tsched_pkg::cmd_type cmd;
   tsched_pkg::sts_type sts;

   tsched_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tsched_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tsched_dp #(
      .NUM_TASKS (NUM_TASKS),
      .TICK_BITS (TICK_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .cfg                 (cfg),
      .req_kind            (req_kind),
      .req_task_id         (req_task_id),
      .req_service_time    (req_service_time),
      .rsp_tick_number     (rsp_tick_number),
      .rsp_running_valid   (rsp_running_valid),
      .rsp_running_id      (rsp_running_id),
      .rsp_remaining       (rsp_remaining),
      .rsp_done_valid      (rsp_done_valid),
      .rsp_done_id         (rsp_done_id),
      .rsp_done_wait       (rsp_done_wait),
      .rsp_done_turnaround (rsp_done_turnaround),
      .rsp_rejected        (rsp_rejected)
   );

endmodule : task_scheduler_fcfs_round_robin_top
`default_nettype wire
